// File: hw/rtl/uvw_pkg.sv
// ----------------------------------------------------------------------------
// UV warp package
// Shared types, fixed-point constants and the sine table generator for the
// UV mirror, flip and ripple warp unit.
// ----------------------------------------------------------------------------
package uvw_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 20;
    localparam int WEIGHT_W  = 17;
    localparam int FRAME_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SINE_W    = 16;

    localparam logic [WEIGHT_W-1:0] ONE_W = WEIGHT_W'(1 << FRAC_BITS);
    localparam logic signed [23:0]  ONE_S  = 24'sd65536;
    localparam logic signed [23:0]  HALF_S = 24'sd32768;
    localparam logic signed [23:0]  COORD_MAX_S = 24'sd524287;
    localparam logic signed [23:0]  COORD_MIN_S = -24'sd524288;
    localparam logic [FRAME_W-1:0]  PHASE_PER_FRAME = 32'd34178264;

    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_NUMBER  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] u_in;
        logic signed [COORD_W-1:0] v_in;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] u_out;
        logic signed [COORD_W-1:0] v_out;
    } result_t;

    // Rounding right shift: floor(a / 2^sh + 1/2).
    function automatic longint rnd_shift(input longint a, input int unsigned sh);
        return (a + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // One quarter-wave sine entry in Q15 from an odd degree-9 polynomial in Q30.
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned tab_bits);
        longint x;
        longint x2;
        longint r;
        longint s;
        x  = longint'(idx) << (30 - tab_bits);
        x2 = rnd_shift(x * x, 30);
        r  = 64'sd172272;
        r  = -64'sd5026995    + rnd_shift(r * x2, 30);
        r  = 64'sd85569306    + rnd_shift(r * x2, 30);
        r  = -64'sd693598669  + rnd_shift(r * x2, 30);
        r  = 64'sd1686629713  + rnd_shift(r * x2, 30);
        s  = rnd_shift(rnd_shift(r * x, 30), 15);
        if (s < 0)
        begin
            s = 0;
        end
        if (s > 32768)
        begin
            s = 32768;
        end
        return SINE_W'(s);
    endfunction

endpackage

// File: hw/rtl/uv_mirror_flip_ripple_warp_unit.sv
// ----------------------------------------------------------------------------
// UV mirror, flip and ripple warp unit
// Warps one signed Q4.16 texture coordinate pair per transaction.
// ----------------------------------------------------------------------------
// The item channel (item_valid, item_stall, item) carries u and v in; the
// result channel (result_valid, result_stall, result) carries the warped
// pair out, one result for every item, in order.
// The write port (cfg_we, cfg_index, cfg_data) loads mirror, invert and pulse
// weights and frame number; derived factors are computed at the write, so the
// user must write the port only with no transaction in flight; unchecked.
// The datapath is five register stages: blend, squash, phase and table index,
// sine table read, and ripple with saturation into the output register.
// An accepted transaction is registered in each stage in turn and leaves as a
// result from the output register. One transaction enters every cycle while
// item_stall is low.
// Each stage advances on its own when the stage after it has room, so a
// stalled result holds in the output register and bubbles behind it close up.
// item_stall rises only when every stage holds a transaction and the result
// is stalled.
// Reset clears all valid bits and returns the weights and the frame number to
// zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module uv_mirror_flip_ripple_warp_unit #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  uvw_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output uvw_pkg::result_t                   result,
    input  logic                               cfg_we,
    input  logic [uvw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [uvw_pkg::FRAME_W-1:0]        cfg_data
);
    import uvw_pkg::*;

    localparam int TAB_N = 1 << SINE_TABLE_BITS;
    localparam int IDX_W = SINE_TABLE_BITS + 1;
    localparam int PH_SHIFT = FRAME_W - FRAC_BITS;

    typedef struct packed {
        logic signed [21:0] u_b;
        logic signed [21:0] v_b;
    } s1_t;

    typedef struct packed {
        logic signed [21:0] u_b;
        logic signed [23:0] v_s;
    } s2_t;

    typedef struct packed {
        logic signed [21:0] u_b;
        logic signed [23:0] v_s;
        logic [IDX_W-1:0]   idx;
        logic               neg;
    } s3_t;

    typedef struct packed {
        logic signed [21:0] u_b;
        logic signed [23:0] v_s;
        logic signed [16:0] sval;
    } s4_t;

    function automatic logic signed [COORD_W-1:0] sat20(input logic signed [23:0] x);
        logic signed [23:0] y;
        y = x;
        if (y < COORD_MIN_S)
        begin
            y = COORD_MIN_S;
        end
        if (y > COORD_MAX_S)
        begin
            y = COORD_MAX_S;
        end
        return COORD_W'(y);
    endfunction

    logic [WEIGHT_W-1:0] mw_reg;
    logic [WEIGHT_W-1:0] factor_reg;
    logic [8:0]          amp_reg;
    logic [FRAME_W-1:0]  phase_base_reg;
    logic [WEIGHT_W-1:0] wclamp;
    logic [WEIGHT_W-1:0] factor_next;
    logic [8:0]          amp_next;
    logic [FRAME_W-1:0]  phase_base_next;
    logic [WEIGHT_W-1:0] inv_sum;
    logic [31:0]         inv_prod;
    logic [WEIGHT_W-1:0] pls_sum;
    logic [28:0]         pls_prod;
    logic [57:0]         frame_prod;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
    s1_t     s1_reg, s1_next;
    s2_t     s2_reg, s2_next;
    s3_t     s3_reg, s3_next;
    s4_t     s4_reg, s4_next;
    result_t s5_reg, s5_next;

    logic [SINE_W-1:0] sine_rom [TAB_N+1];

    for (genvar gi = 0; gi <= TAB_N; gi++)
    begin : g_rom
        assign sine_rom[gi] = sine_entry(gi, SINE_TABLE_BITS);
    end

    // Configuration: clamp the weight and precompute the squash factor,
    // ripple amplitude and frame phase at write time.
    always_comb
    begin
        wclamp = (cfg_data[WEIGHT_W-1:0] > ONE_W) ? ONE_W : cfg_data[WEIGHT_W-1:0];
        inv_sum = wclamp + WEIGHT_W'(10);
        inv_prod = 32'(inv_sum[WEIGHT_W-1:2]) * 32'd52429;
        factor_next = ONE_W + WEIGHT_W'(inv_prod[31:18]);
        pls_sum = wclamp + WEIGHT_W'(100);
        pls_prod = 29'(pls_sum[WEIGHT_W-1:3]) * 29'd41944;
        amp_next = pls_prod[28:20];
        frame_prod = 58'(cfg_data) * 58'(PHASE_PER_FRAME);
        phase_base_next = frame_prod[FRAME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mw_reg         <= '0;
            factor_reg     <= ONE_W;
            amp_reg        <= '0;
            phase_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIRROR_WEIGHT: mw_reg <= wclamp;
                CFG_INVERT_WEIGHT: factor_reg <= factor_next;
                CFG_PULSE_WEIGHT:  amp_reg <= amp_next;
                CFG_FRAME_NUMBER:  phase_base_reg <= phase_base_next;
                default:           mw_reg <= mw_reg;
            endcase
        end
    end

    // The invert weight also enters through the blend, so it is kept too.
    logic [WEIGHT_W-1:0] iw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= '0;
        end
        else if (cfg_we && (cfg_index == CFG_INVERT_WEIGHT))
        begin
            iw_reg <= wclamp;
        end
    end

    assign s5_ready   = !s5_valid_reg || !result_stall;
    assign s4_ready   = !s4_valid_reg || s5_ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_stall = !s1_ready;

    // Stage 1: blend x toward 1-x, written as x + w*(1-2x) rounded.
    always_comb
    begin
        logic signed [21:0] du;
        logic signed [21:0] dv;
        logic signed [39:0] pu;
        logic signed [39:0] pv;
        logic signed [39:0] ru;
        logic signed [39:0] rv;
        du = 22'(ONE_S) - (22'(item.u_in) <<< 1);
        dv = 22'(ONE_S) - (22'(item.v_in) <<< 1);
        pu = 40'(du) * 40'($signed({1'b0, mw_reg}));
        pv = 40'(dv) * 40'($signed({1'b0, iw_reg}));
        ru = (pu + 40'(HALF_S)) >>> FRAC_BITS;
        rv = (pv + 40'(HALF_S)) >>> FRAC_BITS;
        s1_next.u_b = 22'(item.u_in) + 22'(ru);
        s1_next.v_b = 22'(item.v_in) + 22'(rv);
    end

    // Stage 2: squash v about one half.
    always_comb
    begin
        logic signed [22:0] dv;
        logic signed [40:0] pv;
        logic signed [40:0] rv;
        dv = 23'(s1_reg.v_b) - 23'(HALF_S);
        pv = 41'(dv) * 41'($signed({1'b0, factor_reg}));
        rv = (pv + 41'(HALF_S)) >>> FRAC_BITS;
        s2_next.u_b = s1_reg.u_b;
        s2_next.v_s = HALF_S + 24'(rv);
    end

    // Stage 3: ripple phase and quarter-wave table index.
    always_comb
    begin
        logic [FRAME_W-1:0] ph;
        logic [30:0]        rem_sum;
        logic [IDX_W-1:0]   idx;
        ph = phase_base_reg + {s2_reg.v_s[PH_SHIFT-1:0], {FRAC_BITS{1'b0}}};
        rem_sum = {1'b0, ph[29:0]} + 31'(1 << (29 - SINE_TABLE_BITS));
        idx = rem_sum[30 -: IDX_W];
        s3_next.u_b = s2_reg.u_b;
        s3_next.v_s = s2_reg.v_s;
        s3_next.idx = ph[30] ? (IDX_W'(TAB_N) - idx) : idx;
        s3_next.neg = ph[31];
    end

    // Stage 4: table read and sign.
    always_comb
    begin
        logic signed [16:0] rv;
        rv = $signed({1'b0, sine_rom[s3_reg.idx]});
        s4_next.u_b  = s3_reg.u_b;
        s4_next.v_s  = s3_reg.v_s;
        s4_next.sval = s3_reg.neg ? -rv : rv;
    end

    // Stage 5: add the ripple to u and saturate both coordinates.
    always_comb
    begin
        logic signed [26:0] pr;
        logic signed [26:0] rp;
        logic signed [23:0] uf;
        pr = 27'($signed({1'b0, amp_reg})) * 27'(s4_reg.sval);
        rp = (pr + 27'sd16384) >>> 15;
        uf = 24'(s4_reg.u_b) + 24'(rp);
        s5_next.u_out = sat20(uf);
        s5_next.v_out = sat20(s4_reg.v_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_reg <= s5_next;
        end
    end

    assign result_valid = s5_valid_reg;
    assign result       = s5_reg;

endmodule

// File: hw/rtl/uvw_checker.sv
// ----------------------------------------------------------------------------
// UV warp port checker
// Watches the ports of the warp unit for handshake and pipeline behavior.
// ----------------------------------------------------------------------------
module uvw_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input uvw_pkg::result_t result
);
    import uvw_pkg::*;

    // A stalled result stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result_valid dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // With an empty output register the pipeline always has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item_stall high while no result is held");

    // An accepted transaction reaches the output when the result does not stall in between.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) ##1 !result_stall ##1 !result_stall
            ##1 !result_stall ##1 !result_stall |=> result_valid)
        else $error("result missing five cycles after acceptance");

endmodule

bind uv_mirror_flip_ripple_warp_unit uvw_checker u_uvw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
